[design/tcq_pkg.sv]
// Shared types and constants for the two-class age-ordered queue.
package tcq_pkg;

    localparam int ITEM_W  = 32;
    localparam int SEQ_W   = 16;
    localparam int ENTRY_W = ITEM_W + SEQ_W;
    localparam int NCLS    = 2;

    localparam int CLS_POS = 0;
    localparam int CLS_NEG = 1;

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    localparam logic [1:0] TAKE_ANY  = 2'd0;
    localparam logic [1:0] TAKE_POS  = 2'd1;
    localparam logic [1:0] TAKE_NEG  = 2'd2;
    localparam logic [1:0] TAKE_NONE = 2'd3;

    localparam logic STS_SERVED = 1'b0;
    localparam logic STS_FULL   = 1'b1;

    typedef struct packed {
        logic                      cmd;
        logic signed [ITEM_W-1:0]  item;
        logic [1:0]                take;
    } t_in;

    typedef struct packed {
        logic signed [ITEM_W-1:0]  item_out;
        logic                      status;
    } t_out;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic             latch_in;
        logic [NCLS-1:0]  push;
        logic [NCLS-1:0]  pop;
        logic             load_out;
        logic             out_status;
    } t_ctl_cmd;

    typedef struct packed {
        logic             cmd;
        logic [1:0]       take;
        logic             item_pos;
        logic [NCLS-1:0]  empty;
        logic [NCLS-1:0]  full;
        logic             pos_older;
        logic             out_busy;
    } t_dp_stat;

endpackage

[design/tcq_ctrl.sv]
// Controller state machine: accepts one transfer, then decides pushes, pops and results.
module tcq_ctrl import tcq_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_dp_stat i_stat,
    output logic     o_in_ready,
    output t_ctl_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        t_ctl_cmd c;
        c          = '0;
        n_state    = r_state;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                c.latch_in = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.cmd == CMD_ENQ) begin
                    if (i_stat.item_pos) begin
                        if (i_stat.full[CLS_POS]) begin
                            c.load_out   = 1'b1;
                            c.out_status = STS_FULL;
                        end else begin
                            c.push[CLS_POS] = 1'b1;
                        end
                    end else begin
                        if (i_stat.full[CLS_NEG]) begin
                            c.load_out   = 1'b1;
                            c.out_status = STS_FULL;
                        end else begin
                            c.push[CLS_NEG] = 1'b1;
                        end
                    end
                end else begin
                    case (i_stat.take)
                        TAKE_ANY: begin
                            if (i_stat.empty[CLS_NEG] && !i_stat.empty[CLS_POS]) begin
                                c.pop[CLS_POS] = 1'b1;
                            end else if (i_stat.empty[CLS_POS] && !i_stat.empty[CLS_NEG]) begin
                                c.pop[CLS_NEG] = 1'b1;
                            end else if (!i_stat.empty[CLS_POS]) begin
                                if (i_stat.pos_older) begin
                                    c.pop[CLS_POS] = 1'b1;
                                end else begin
                                    c.pop[CLS_NEG] = 1'b1;
                                end
                            end
                        end
                        TAKE_POS: begin
                            c.pop[CLS_POS] = !i_stat.empty[CLS_POS];
                        end
                        TAKE_NEG: begin
                            c.pop[CLS_NEG] = !i_stat.empty[CLS_NEG];
                        end
                        default: begin
                            c.pop = '0;
                        end
                    endcase
                    c.load_out   = |c.pop;
                    c.out_status = STS_SERVED;
                end
                if (c.load_out && i_stat.out_busy) begin
                    c = '0;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        o_cmd = c;
    end

endmodule

[design/tcq_dpath.sv]
// Datapath: two class FIFOs with sequence tags, arrival counter, input latch, output register.
module tcq_dpath import tcq_pkg::*; #(
    parameter int FIFO_DEPTH = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_in      i_in_data,
    input  t_ctl_cmd i_cmd,
    input  logic     i_out_stall,
    output t_dp_stat o_stat,
    output logic     o_out_valid,
    output t_out     o_out_data
);

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int SUM_W = PTR_W + 1;

    t_in              r_in;
    logic [SEQ_W-1:0] r_seq;
    logic             r_out_valid;
    t_out             r_out;

    logic [ENTRY_W-1:0] w_rd    [NCLS];
    logic [NCLS-1:0]    w_empty;
    logic [NCLS-1:0]    w_full;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq <= '0;
        end else if (|i_cmd.push) begin
            r_seq <= r_seq + SEQ_W'(1);
        end
    end

    for (genvar g = 0; g < NCLS; g++) begin : g_fifo
        logic [ENTRY_W-1:0] mem [FIFO_DEPTH];
        logic [PTR_W-1:0]   r_head;
        logic [CNT_W-1:0]   r_fill;
        logic [ENTRY_W-1:0] r_rd;
        logic [SUM_W-1:0]   w_tail_sum;
        logic [SUM_W-1:0]   w_head_inc;
        logic [PTR_W-1:0]   w_tail;
        logic [PTR_W-1:0]   w_head_nxt;

        always_comb begin
            w_tail_sum = SUM_W'(r_head) + SUM_W'(r_fill);
            w_head_inc = SUM_W'(r_head) + SUM_W'(1);
            w_tail     = (w_tail_sum >= SUM_W'(FIFO_DEPTH))
                       ? PTR_W'(w_tail_sum - SUM_W'(FIFO_DEPTH)) : PTR_W'(w_tail_sum);
            w_head_nxt = (w_head_inc == SUM_W'(FIFO_DEPTH)) ? '0 : PTR_W'(w_head_inc);
        end

        always_ff @(posedge i_clk) begin
            if (i_cmd.push[g]) begin
                mem[w_tail] <= {r_seq, r_in.item};
            end
            r_rd <= mem[r_head];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_head <= '0;
                r_fill <= '0;
            end else begin
                if (i_cmd.pop[g]) begin
                    r_head <= w_head_nxt;
                end
                if (i_cmd.push[g] && !i_cmd.pop[g]) begin
                    r_fill <= r_fill + CNT_W'(1);
                end else if (i_cmd.pop[g] && !i_cmd.push[g]) begin
                    r_fill <= r_fill - CNT_W'(1);
                end
            end
        end

        assign w_rd[g]    = r_rd;
        assign w_empty[g] = (r_fill == '0);
        assign w_full[g]  = (r_fill == CNT_W'(FIFO_DEPTH));
    end

    logic [SEQ_W-1:0] w_age_diff;
    assign w_age_diff = w_rd[CLS_POS][ENTRY_W-1:ITEM_W] - w_rd[CLS_NEG][ENTRY_W-1:ITEM_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.status <= i_cmd.out_status;
            if (i_cmd.out_status == STS_FULL) begin
                r_out.item_out <= r_in.item;
            end else if (i_cmd.pop[CLS_POS]) begin
                r_out.item_out <= w_rd[CLS_POS][ITEM_W-1:0];
            end else begin
                r_out.item_out <= w_rd[CLS_NEG][ITEM_W-1:0];
            end
        end
    end

    always_comb begin
        o_stat.cmd       = r_in.cmd;
        o_stat.take      = r_in.take;
        o_stat.item_pos  = (r_in.item > 0);
        o_stat.empty     = w_empty;
        o_stat.full      = w_full;
        o_stat.pos_older = w_age_diff[SEQ_W-1];
        o_stat.out_busy  = r_out_valid && i_out_stall;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[design/two_class_age_ordered_queue_unit.sv]
// Two-class age-ordered queue: one input transfer at a time.
// The input transfer is latched; any result is then loaded into the output register.
// A new transfer is taken only after the last is executed; execution waits on a stalled output.
// The head entries are read from the FIFO memories through one registered read port each.
// Reset (synchronous, active low) empties both FIFOs and zeroes the arrival counter.
// FIFO memories are not cleared; entries are only used after they are written.
module two_class_age_ordered_queue_unit import tcq_pkg::*; #(
    parameter int FIFO_DEPTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    t_ctl_cmd w_cmd;
    t_dp_stat w_stat;
    logic     w_in_ready;

    tcq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (w_stat),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    tcq_dpath #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .i_out_stall (i_out_stall),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    assign o_in_stall = !w_in_ready;

`ifndef SYNTHESIS
    a_one_fifo_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.push, w_cmd.pop}))
        else $error("more than one FIFO operation in a cycle");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> !(o_out_valid && i_out_stall))
        else $error("output register loaded while its transfer is stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted again right after a transfer");

    a_result_only_on_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.load_out && (w_cmd.out_status == STS_SERVED)) |-> (|w_cmd.pop))
        else $error("served result without a pop");
`endif

endmodule

[tb/sv/two_class_age_ordered_queue_unit_test.sv]
// Self-checking testbench for the two-class age-ordered queue: directed table, random mix.
module two_class_age_ordered_queue_unit_test;
    import tcq_pkg::*;

    localparam int DEPTH      = 16;
    localparam int CYCLE_CAP  = 1_500_000;
    localparam int SETTLE     = 10;
    localparam int NROWS      = 23;

    typedef struct packed {
        t_in        stim;
        logic       typed;
        logic       has;
        t_out       want;
        logic [4:0] reps;
    } t_row;

    localparam t_row ROWS [NROWS] = '{
        '{'{CMD_DEQ, 32'sh00000000, TAKE_ANY},  1'b1, 1'b0, '{32'sh0, STS_SERVED}, 5'd1},
        '{'{CMD_DEQ, 32'shffffffff, TAKE_POS},  1'b1, 1'b0, '{32'sh0, STS_SERVED}, 5'd1},
        '{'{CMD_DEQ, 32'sh7fffffff, TAKE_NEG},  1'b1, 1'b0, '{32'sh0, STS_SERVED}, 5'd1},
        '{'{CMD_DEQ, 32'sh80000000, TAKE_NONE}, 1'b1, 1'b0, '{32'sh0, STS_SERVED}, 5'd1},
        '{'{CMD_ENQ, 32'sh7fffffff, TAKE_NONE}, 1'b1, 1'b0, '{32'sh0, STS_SERVED}, 5'd1},
        '{'{CMD_ENQ, 32'sh80000000, TAKE_ANY},  1'b1, 1'b0, '{32'sh0, STS_SERVED}, 5'd1},
        '{'{CMD_ENQ, 32'sh00000000, TAKE_POS},  1'b1, 1'b0, '{32'sh0, STS_SERVED}, 5'd1},
        '{'{CMD_ENQ, 32'sh00000001, TAKE_NEG},  1'b1, 1'b0, '{32'sh0, STS_SERVED}, 5'd1},
        '{'{CMD_ENQ, 32'shffffffff, TAKE_NONE}, 1'b1, 1'b0, '{32'sh0, STS_SERVED}, 5'd1},
        '{'{CMD_DEQ, 32'sh12345678, TAKE_ANY},  1'b1, 1'b1,
          '{32'sh7fffffff, STS_SERVED}, 5'd1},
        '{'{CMD_DEQ, 32'sh00000000, TAKE_NONE}, 1'b1, 1'b0, '{32'sh0, STS_SERVED}, 5'd1},
        '{'{CMD_DEQ, 32'shedcba987, TAKE_ANY},  1'b1, 1'b1,
          '{32'sh80000000, STS_SERVED}, 5'd1},
        '{'{CMD_DEQ, 32'sh00000000, TAKE_POS},  1'b1, 1'b1,
          '{32'sh00000001, STS_SERVED}, 5'd1},
        '{'{CMD_DEQ, 32'sh00000000, TAKE_NEG},  1'b1, 1'b1,
          '{32'sh00000000, STS_SERVED}, 5'd1},
        '{'{CMD_DEQ, 32'sh00000000, TAKE_NEG},  1'b1, 1'b1,
          '{32'shffffffff, STS_SERVED}, 5'd1},
        '{'{CMD_DEQ, 32'sh00000000, TAKE_ANY},  1'b1, 1'b0, '{32'sh0, STS_SERVED}, 5'd1},
        '{'{CMD_ENQ, 32'sh00000002, TAKE_ANY},  1'b1, 1'b0, '{32'sh0, STS_SERVED}, 5'd16},
        '{'{CMD_ENQ, 32'sh00000003, TAKE_NONE}, 1'b1, 1'b1,
          '{32'sh00000003, STS_FULL}, 5'd1},
        '{'{CMD_ENQ, 32'shfffffffb, TAKE_POS},  1'b1, 1'b0, '{32'sh0, STS_SERVED}, 5'd1},
        '{'{CMD_DEQ, 32'sh00000000, TAKE_POS},  1'b0, 1'b0, '{32'sh0, STS_SERVED}, 5'd1},
        '{'{CMD_DEQ, 32'sh00000000, TAKE_ANY},  1'b0, 1'b0, '{32'sh0, STS_SERVED}, 5'd1},
        '{'{CMD_DEQ, 32'sh00000000, TAKE_NEG},  1'b0, 1'b0, '{32'sh0, STS_SERVED}, 5'd1},
        '{'{CMD_DEQ, 32'sh00000000, TAKE_ANY},  1'b0, 1'b0, '{32'sh0, STS_SERVED}, 5'd16}
    };

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    t_in  i_in_data   = '0;
    logic i_out_stall = 1'b0;
    logic o_in_stall;
    logic o_out_valid;
    t_out o_out_data;

    // predictor state
    logic [ENTRY_W-1:0] cls_mem [NCLS][DEPTH];
    int                 cls_head [NCLS];
    int                 cls_fill [NCLS];
    logic [SEQ_W-1:0]   seq_next;

    t_out release_due [$];

    int  in_idle_pct  = 0;
    int  out_idle_pct = 0;
    bit  hold_req     = 1'b0;
    int  hold_left    = 0;
    int  cycles       = 0;
    int  errors       = 0;
    int  n_items      = 0;
    int  n_served     = 0;
    int  n_dropped    = 0;

    two_class_age_ordered_queue_unit #(
        .FIFO_DEPTH (DEPTH)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_CAP) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic add_due(input t_out r);
        release_due.insert(release_due.size(), r);
    endtask

    // served head, or rejected item when the class FIFO is full
    function automatic bit predict_release(input t_in x, output t_out r);
        int               c;
        int               sel;
        logic [SEQ_W-1:0] d;
        r = '0;
        if (x.cmd == CMD_ENQ) begin
            c = (!x.item[ITEM_W-1] && x.item != 0) ? CLS_POS : CLS_NEG;
            if (cls_fill[c] == DEPTH) begin
                r.item_out = x.item;
                r.status   = STS_FULL;
                return 1'b1;
            end
            cls_mem[c][(cls_head[c] + cls_fill[c]) % DEPTH] = {seq_next, x.item};
            cls_fill[c]++;
            seq_next++;
            return 1'b0;
        end
        case (x.take)
            TAKE_ANY: begin
                if (cls_fill[CLS_POS] == 0 && cls_fill[CLS_NEG] == 0) return 1'b0;
                if (cls_fill[CLS_NEG] == 0) sel = CLS_POS;
                else if (cls_fill[CLS_POS] == 0) sel = CLS_NEG;
                else begin
                    d = cls_mem[CLS_POS][cls_head[CLS_POS]][ENTRY_W-1:ITEM_W]
                        - cls_mem[CLS_NEG][cls_head[CLS_NEG]][ENTRY_W-1:ITEM_W];
                    sel = d[SEQ_W-1] ? CLS_POS : CLS_NEG;
                end
            end
            TAKE_POS: begin
                if (cls_fill[CLS_POS] == 0) return 1'b0;
                sel = CLS_POS;
            end
            TAKE_NEG: begin
                if (cls_fill[CLS_NEG] == 0) return 1'b0;
                sel = CLS_NEG;
            end
            default: return 1'b0;
        endcase
        r.item_out    = cls_mem[sel][cls_head[sel]][ITEM_W-1:0];
        r.status      = STS_SERVED;
        cls_head[sel] = (cls_head[sel] + 1) % DEPTH;
        cls_fill[sel]--;
        return 1'b1;
    endfunction

    function automatic logic signed [ITEM_W-1:0] rand_item();
        case ($urandom_range(9))
            0: return 32'sh00000000;
            1: return 32'sh00000001;
            2: return 32'shffffffff;
            3: return 32'sh7fffffff;
            4: return 32'sh80000000;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in rand_op(input int enq_pct);
        t_in x;
        x.cmd  = ($urandom_range(99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
        x.item = rand_item();
        x.take = 2'($urandom_range(3));
        if (x.take == TAKE_NONE && $urandom_range(1) == 0) x.take = TAKE_ANY;
        return x;
    endfunction

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic offer(input t_in x, input bit typed, input bit has, input t_out want);
        t_out r;
        bit   got;
        while (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= x;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        got = predict_release(x, r);
        if (typed) begin
            if (has) add_due(want);
        end else if (got) begin
            add_due(r);
        end
        n_items++;
        @(negedge i_clk);
    endtask

    task automatic run_random(input int count);
        int enq_pct;
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0) begin
                case ($urandom_range(2))
                    0: enq_pct = 25;
                    1: enq_pct = 50;
                    default: enq_pct = 85;
                endcase
            end
            offer(rand_op(enq_pct), 1'b0, 1'b0, '0);
        end
    endtask

    task automatic note_mismatch(input string what, input logic [ITEM_W-1:0] e,
                                 input logic [ITEM_W-1:0] a);
        errors++;
        $display("%0t mismatch %s: expected %h actual %h", $time, what, e, a);
    endtask

    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = 400;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= (out_idle_pct != 0) && ($urandom_range(99) < out_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_out exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (release_due.size() == 0) begin
                note_mismatch("unexpected transfer", '0, o_out_data.item_out);
            end else begin
                exp_r = release_due.pop_front();
                if (o_out_data.item_out !== exp_r.item_out)
                    note_mismatch("item_out", exp_r.item_out, o_out_data.item_out);
                if (o_out_data.status !== exp_r.status)
                    note_mismatch("status", ITEM_W'(exp_r.status),
                                  ITEM_W'(o_out_data.status));
                if (exp_r.status == STS_FULL) n_dropped++;
                else n_served++;
            end
        end
    end

    initial begin
        t_row row;
        for (int c = 0; c < NCLS; c++) begin
            cls_head[c] = 0;
            cls_fill[c] = 0;
        end
        seq_next = '0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        in_idle_pct  = 19;
        out_idle_pct = 65;
        for (int k = 0; k < NROWS; k++) begin
            row = ROWS[k];
            for (int n = 0; n < row.reps; n++)
                offer(row.stim, row.typed, row.has, row.want);
        end
        run_random(330);

        in_idle_pct  = 65;
        out_idle_pct = 19;
        run_random(330);

        in_idle_pct  = 0;
        out_idle_pct = 0;
        hold_req     = 1'b1;
        run_random(340);
        i_in_valid <= 1'b0;

        while (release_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        $display("%0d input transfers: %0d items served, %0d enqueues dropped as full",
                 n_items, n_served, n_dropped);
        $display("phases: both idle mixes, no idling, long output hold");
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
